FILE: hdl/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_BITS  = 32;
    localparam int PRIO_BITS  = 8;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    // Stream word layout, lowest field first, padded to whole bytes.
    localparam int IN_BITS    = PRIO_BITS + DATA_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = 2 * PRIO_BITS + 2 * DATA_BITS + 1 + COUNT_BITS;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    // Broadcast from the queue control to every cell.
    typedef struct packed {
        logic                 ins;
        logic                 pop;
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
    } t_cell_ctl;

endpackage

FILE: hdl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic                 i_occ,
    input  logic                 i_prev_gt,
    input  logic [PRIO_BITS-1:0] i_prev_prio,
    input  logic [DATA_BITS-1:0] i_prev_data,
    input  logic [PRIO_BITS-1:0] i_next_prio,
    input  logic [DATA_BITS-1:0] i_next_data,
    output logic                 o_gt,
    output logic [PRIO_BITS-1:0] o_prio,
    output logic [DATA_BITS-1:0] o_data,
    output logic [PRIO_BITS-1:0] o_nxt_prio,
    output logic [DATA_BITS-1:0] o_nxt_data
);

    logic [PRIO_BITS-1:0] r_prio;
    logic [DATA_BITS-1:0] r_data;
    logic [PRIO_BITS-1:0] n_prio;
    logic [DATA_BITS-1:0] n_data;

    // The new entry goes behind every stored entry of lower or equal priority.
    assign o_gt = i_occ && (r_prio > i_ctl.prio);

    always_comb begin
        n_prio = r_prio;
        n_data = r_data;
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                n_prio = i_prev_prio;
                n_data = i_prev_data;
            end else if (!i_occ || (r_prio > i_ctl.prio)) begin
                n_prio = i_ctl.prio;
                n_data = i_ctl.data;
            end
        end else if (i_ctl.pop) begin
            n_prio = i_next_prio;
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_data <= n_data;
    end

    assign o_prio     = r_prio;
    assign o_data     = r_data;
    assign o_nxt_prio = n_prio;
    assign o_nxt_data = n_data;

endmodule

FILE: hdl/sorted_priority_queue_core.sv
// Channel   Dir  tdata (lowest bit first)                          tuser
// s_axis    in   prio_in[7:0], data_in[39:8]                       action
// m_axis    out  popped_prio[7:0], popped_data[39:8],              done_res
//                head_valid[40], head_prio[48:41],
//                head_data[80:49], fill_count[85:81]
//
// One word is taken per cycle unless m_axis stalls; its result word follows in the next cycle.
// The cell row shifts or compares all slots in the same cycle it takes a word.
// A single output register holds the result; a new word is taken whenever it
// is empty or being drained, so a stall on m_axis stalls s_axis.
// Reset (synchronous, active low) empties the queue and drops any result.
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [8*IN_BYTES-1:0]  i_s_axis_tdata,  // prio_in, data_in
    input  logic                   i_s_axis_tuser,  // action
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [8*OUT_BYTES-1:0] o_m_axis_tdata,  // popped_prio, popped_data,
                                                     // head_valid, head_prio,
                                                     // head_data, fill_count
    output logic                   o_m_axis_tuser   // done_res
);

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_ovalid;
    logic [OUT_BITS-1:0]   r_odata;
    logic                  r_odone;

    logic                  in_fire;
    logic                  full;
    logic                  empty;
    t_cell_ctl             ctl;

    logic [PRIO_BITS-1:0]  cell_prio [CAPACITY];
    logic [DATA_BITS-1:0]  cell_data [CAPACITY];
    logic [PRIO_BITS-1:0]  nxt_prio  [CAPACITY];
    logic [DATA_BITS-1:0]  nxt_data  [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;
    logic [CAPACITY-1:0]   occ;

    logic                  done;
    logic [PRIO_BITS-1:0]  pop_prio;
    logic [DATA_BITS-1:0]  pop_data;
    logic                  hd_valid;
    logic [PRIO_BITS-1:0]  hd_prio;
    logic [DATA_BITS-1:0]  hd_data;

    assign o_s_axis_tready = !r_ovalid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign full  = (r_count == COUNT_BITS'(CAPACITY));
    assign empty = (r_count == '0);

    assign ctl.ins  = in_fire && (i_s_axis_tuser == ACT_INSERT) && !full;
    assign ctl.pop  = in_fire && (i_s_axis_tuser == ACT_POP) && !empty;
    assign ctl.prio = i_s_axis_tdata[PRIO_BITS-1:0];
    assign ctl.data = i_s_axis_tdata[PRIO_BITS +: DATA_BITS];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 prev_gt;
            logic [PRIO_BITS-1:0] prev_prio;
            logic [DATA_BITS-1:0] prev_data;
            logic [PRIO_BITS-1:0] next_prio;
            logic [DATA_BITS-1:0] next_data;

            assign occ[g] = (r_count > COUNT_BITS'(g));

            if (g == 0) begin : g_first
                assign prev_gt   = 1'b0;
                assign prev_prio = '0;
                assign prev_data = '0;
            end else begin : g_mid
                assign prev_gt   = cell_gt[g-1];
                assign prev_prio = cell_prio[g-1];
                assign prev_data = cell_data[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign next_prio = '0;
                assign next_data = '0;
            end else begin : g_body
                assign next_prio = cell_prio[g+1];
                assign next_data = cell_data[g+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_occ       (occ[g]),
                .i_prev_gt   (prev_gt),
                .i_prev_prio (prev_prio),
                .i_prev_data (prev_data),
                .i_next_prio (next_prio),
                .i_next_data (next_data),
                .o_gt        (cell_gt[g]),
                .o_prio      (cell_prio[g]),
                .o_data      (cell_data[g]),
                .o_nxt_prio  (nxt_prio[g]),
                .o_nxt_data  (nxt_data[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + COUNT_BITS'(1);
        end else if (ctl.pop) begin
            n_count = r_count - COUNT_BITS'(1);
        end
    end

    assign done     = ctl.ins || ctl.pop;
    assign pop_prio = ctl.pop ? cell_prio[0] : '0;
    assign pop_data = ctl.pop ? cell_data[0] : '0;
    assign hd_valid = (n_count != '0);
    assign hd_prio  = hd_valid ? nxt_prio[0] : '0;
    assign hd_data  = hd_valid ? nxt_data[0] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_fire) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_odone <= done;
            r_odata <= {n_count, hd_data, hd_prio, hd_valid, pop_data, pop_prio};
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_odone;
    assign o_m_axis_tdata  = {{(8*OUT_BYTES-OUT_BITS){1'b0}}, r_odata};

endmodule

FILE: hdl/spq_checker.sv
module spq_checker
    import spq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tready,
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [8*OUT_BYTES-1:0] i_m_axis_tdata,
    input  logic                   i_m_axis_tuser
);

    localparam int HV_POS = PRIO_BITS + DATA_BITS;
    localparam int FC_POS = 2 * PRIO_BITS + 2 * DATA_BITS + 1;

    logic                  hv;
    logic [COUNT_BITS-1:0] fc;
    logic [PRIO_BITS-1:0]  pp;
    logic [DATA_BITS-1:0]  pd;
    logic [PRIO_BITS-1:0]  hp;
    logic [DATA_BITS-1:0]  hd;

    assign pp = i_m_axis_tdata[PRIO_BITS-1:0];
    assign pd = i_m_axis_tdata[PRIO_BITS +: DATA_BITS];
    assign hv = i_m_axis_tdata[HV_POS];
    assign hp = i_m_axis_tdata[HV_POS+1 +: PRIO_BITS];
    assign hd = i_m_axis_tdata[HV_POS+1+PRIO_BITS +: DATA_BITS];
    assign fc = i_m_axis_tdata[FC_POS +: COUNT_BITS];

    // A stalled result word must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=> $stable(i_m_axis_tdata))
        else $error("result word changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (fc <= COUNT_BITS'(CAPACITY)) && (hv == (fc != '0)))
        else $error("fill count out of range or head valid mismatch");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !hv |-> (hp == '0) && (hd == '0))
        else $error("empty queue shows a head entry");

    a_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tuser |-> (pp == '0) && (pd == '0))
        else $error("popped fields set on a step that did nothing");

    // The output register blocks new words only while it holds a stalled one.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_m_axis_tvalid |-> i_s_axis_tready)
        else $error("input not ready while output is empty");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spq_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 200000;
    localparam int MAX_PRINTS  = 30;

    // Field offsets inside the result word, lowest field first.
    localparam int O_PD = PRIO_BITS;
    localparam int O_HV = O_PD + DATA_BITS;
    localparam int O_HP = O_HV + 1;
    localparam int O_HD = O_HP + PRIO_BITS;
    localparam int O_FC = O_HD + DATA_BITS;

    typedef struct packed {
        logic                  done;
        logic [PRIO_BITS-1:0]  popped_prio;
        logic [DATA_BITS-1:0]  popped_data;
        logic                  head_valid;
        logic [PRIO_BITS-1:0]  head_prio;
        logic [DATA_BITS-1:0]  head_data;
        logic [COUNT_BITS-1:0] fill;
    } t_status;

    // Shadow copy of the sorted queue and the status words it predicts.
    class queue_shadow;
        logic [PRIO_BITS-1:0] prio_row[CAPACITY];
        logic [DATA_BITS-1:0] data_row[CAPACITY];
        int                   stored;
        t_status              pending_status[$];
        int                   errors;
        int                   n_inserts;
        int                   n_full_refused;
        int                   n_pops;
        int                   n_empty_pops;
        int                   deepest;

        function new();
            stored         = 0;
            errors         = 0;
            n_inserts      = 0;
            n_full_refused = 0;
            n_pops         = 0;
            n_empty_pops   = 0;
            deepest        = 0;
        endfunction

        task flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
            if (errors < MAX_PRINTS)
                $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        function void apply_command(logic act, logic [PRIO_BITS-1:0] prio,
                                    logic [DATA_BITS-1:0] data);
            t_status st;
            int      pos;
            int      i;
            st = '0;
            if (act == ACT_INSERT) begin
                n_inserts++;
                if (stored < CAPACITY) begin
                    pos = 0;
                    // Go past every entry with lower or equal priority: ties keep arrival order.
                    while (pos < stored && prio_row[pos] <= prio)
                        pos++;
                    for (i = stored; i > pos; i--) begin
                        prio_row[i] = prio_row[i-1];
                        data_row[i] = data_row[i-1];
                    end
                    prio_row[pos] = prio;
                    data_row[pos] = data;
                    stored++;
                    st.done = 1'b1;
                end else begin
                    n_full_refused++;
                end
            end else begin
                n_pops++;
                if (stored > 0) begin
                    st.popped_prio = prio_row[0];
                    st.popped_data = data_row[0];
                    for (i = 0; i + 1 < stored; i++) begin
                        prio_row[i] = prio_row[i+1];
                        data_row[i] = data_row[i+1];
                    end
                    stored--;
                    st.done = 1'b1;
                end else begin
                    n_empty_pops++;
                end
            end
            if (stored > 0) begin
                st.head_valid = 1'b1;
                st.head_prio  = prio_row[0];
                st.head_data  = data_row[0];
            end
            st.fill = stored[COUNT_BITS-1:0];
            if (stored > deepest)
                deepest = stored;
            pending_status.push_back(st);
        endfunction

        task check_status_word(logic done, logic [8*OUT_BYTES-1:0] word);
            t_status want;
            if (pending_status.size() == 0) begin
                flag_mismatch("status word with nothing outstanding", word[63:0], 64'h0);
                return;
            end
            want = pending_status.pop_front();
            if (done !== want.done)
                flag_mismatch("done_res", 64'(done), 64'(want.done));
            if (word[0 +: PRIO_BITS] !== want.popped_prio)
                flag_mismatch("popped_prio", 64'(word[0 +: PRIO_BITS]),
                              64'(want.popped_prio));
            if (word[O_PD +: DATA_BITS] !== want.popped_data)
                flag_mismatch("popped_data", 64'(word[O_PD +: DATA_BITS]),
                              64'(want.popped_data));
            if (word[O_HV] !== want.head_valid)
                flag_mismatch("head_valid", 64'(word[O_HV]), 64'(want.head_valid));
            if (word[O_HP +: PRIO_BITS] !== want.head_prio)
                flag_mismatch("head_prio", 64'(word[O_HP +: PRIO_BITS]),
                              64'(want.head_prio));
            if (word[O_HD +: DATA_BITS] !== want.head_data)
                flag_mismatch("head_data", 64'(word[O_HD +: DATA_BITS]),
                              64'(want.head_data));
            if (word[O_FC +: COUNT_BITS] !== want.fill)
                flag_mismatch("fill_count", 64'(word[O_FC +: COUNT_BITS]),
                              64'(want.fill));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [8*IN_BYTES-1:0]  s_tdata;   // prio_in, data_in
    logic                   s_tuser;   // action
    logic                   m_tvalid;
    logic                   m_tready;
    logic [8*OUT_BYTES-1:0] m_tdata;   // popped_prio, popped_data, head_valid,
                                       // head_prio, head_data, fill_count
    logic                   m_tuser;   // done_res

    queue_shadow shadow;
    int          cycle_cnt;
    bit          tx_gaps;
    bit          rx_stalls;
    bit          hold_req;

    sorted_priority_queue_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles", LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Handshake monitor: results are checked first, then the accepted command is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_tvalid && m_tready)
                shadow.check_status_word(m_tuser, m_tdata);
            if (s_tvalid && s_tready)
                shadow.apply_command(s_tuser, s_tdata[0 +: PRIO_BITS],
                                     s_tdata[PRIO_BITS +: DATA_BITS]);
        end
    end

    // Output side: random ready bursts, plus one long hold when asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(0, 12)) @(negedge i_clk);
            end
        end
    end

    task automatic send_word(logic act, logic [PRIO_BITS-1:0] prio,
                             logic [DATA_BITS-1:0] data);
        @(negedge i_clk);
        s_tvalid                         = 1'b1;
        s_tuser                          = act;
        s_tdata                          = '0;
        s_tdata[0 +: PRIO_BITS]          = prio;
        s_tdata[PRIO_BITS +: DATA_BITS]  = data;
        do
            @(posedge i_clk);
        while (!s_tready);
    endtask

    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
        end
    endtask

    task automatic wait_drained();
        sender_gap(1);
        while (shadow.pending_status.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random(int ins_pct);
        logic                 act;
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] data;
        act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_POP;
        case ($urandom_range(0, 3))
            0: begin
                prio = PRIO_BITS'($urandom_range(0, 3));   // dense ties
            end
            1: begin
                prio = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
                prio = PRIO_BITS'($urandom());
            end
        endcase
        case ($urandom_range(0, 9))
            0: begin
                data = '0;
            end
            1: begin
                data = '1;
            end
            default: begin
                data = $urandom();
            end
        endcase
        send_word(act, prio, data);
        if (tx_gaps && $urandom_range(0, 4) == 0)
            sender_gap($urandom_range(1, 13));
    endtask

    initial begin
        int pct_table[5];
        int chunk;
        pct_table = '{85, 15, 50, 70, 30};
        shadow    = new();
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_INSERT;
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty pop, extreme values, ties at the head and in the middle.
        send_word(ACT_POP, 8'h5a, 32'h1234_5678);
        send_word(ACT_INSERT, '1, '1);
        send_word(ACT_INSERT, '0, '0);
        send_word(ACT_INSERT, 8'd128, 32'haaaa_5555);
        send_word(ACT_INSERT, 8'd128, 32'h5555_aaaa);
        send_word(ACT_INSERT, '0, 32'hdead_beef);
        send_word(ACT_INSERT, '1, 32'h0000_0001);
        repeat (6) send_word(ACT_POP, '1, '1);
        send_word(ACT_POP, '0, '0);
        wait_drained();

        for (chunk = 0; chunk < 25; chunk++) begin
            tx_gaps   = ($urandom_range(0, 2) != 0);
            rx_stalls = ($urandom_range(0, 2) != 0);
            if (chunk == 6)
                wait_drained();
            if (chunk == 10) begin
                // Insert-heavy and back to back while the output is held.
                hold_req = 1'b1;
                tx_gaps  = 1'b0;
            end
            repeat (60) send_random(pct_table[chunk % 5]);
        end

        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        repeat (120) send_random(50);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d inserts (%0d refused on a full queue), %0d pops (%0d on empty)",
                 shadow.n_inserts, shadow.n_full_refused, shadow.n_pops,
                 shadow.n_empty_pops);
        $display("deepest fill %0d of %0d; ties, output hold and drain pauses exercised",
                 shadow.deepest, CAPACITY);
        if (shadow.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d field mismatches", shadow.errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
